@@ rtl/mslp_pkg.sv @@
// ----------------------------------------------------------------------------
// mslp_pkg
// Types and constants shared by the slew limited bridge PWM block.
// ----------------------------------------------------------------------------
package mslp_pkg;

  localparam int CMD_W      = 18;
  localparam int TS_W       = 32;
  localparam int DUTY_W     = 8;
  localparam int MAG_W      = 17;
  localparam int MAXR_W     = 20;
  localparam int FLOOR_W    = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAG_W-1:0]     FULL_SCALE      = 17'd65536;
  localparam logic [MAXR_W-1:0]    MAX_RISE_RST    = 20'd16777;
  localparam logic [FLOOR_W-1:0]   FLOOR_RST       = 17'd655;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RISE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL = 8'd1;

  typedef struct packed {
    logic signed [CMD_W-1:0] command;
    logic [TS_W-1:0]         timestamp_us;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic              limited;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mult;
    logic scale;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scale_req;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/mslp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mslp_ctrl
// Sequencer: load, budget multiply, scaling loop, result write.
// ----------------------------------------------------------------------------
module mslp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mslp_pkg::sts_t sts,
  output mslp_pkg::cmd_t cmd
);
  import mslp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MULT,
    S_LOOP,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (sts.scale_req) begin
          cmd.scale = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/mslp_dp.sv @@
// ----------------------------------------------------------------------------
// mslp_dp
// Datapath: magnitude, rise budget, 0.9 scaling, stored state, result register.
// ----------------------------------------------------------------------------
module mslp_dp #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mslp_pkg::in_t                   in_data,
  input  logic                            cfg_we,
  input  logic [mslp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mslp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mslp_pkg::cmd_t                  cmd,
  output mslp_pkg::sts_t                  sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mslp_pkg::out_t                  out_data
);
  import mslp_pkg::*;

  localparam int EL_W  = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
  localparam int BUD_W = MAXR_W + EL_W;
  localparam int RISE_W = MAG_W + 8;
  localparam int M9_W  = MAG_W + 3;
  localparam int RCP_W = 2 * M9_W;
  // ceil(2^23 / 10), exact floor(x / 10) for x below 2^22
  localparam logic [M9_W-1:0] DIV10_MUL = 20'd838861;
  localparam int DIV10_SH = 23;

  logic [MAXR_W-1:0]  max_rise_r;
  logic [FLOOR_W-1:0] floor_r;
  logic [MAG_W-1:0]   last_mag_r;
  logic [TS_W-1:0]    last_time_r;
  logic [MAG_W-1:0]   mag_r;
  logic               neg_r;
  logic               limited_r;
  logic [TS_W-1:0]    ts_r;
  logic [EL_W-1:0]    elapsed_r;
  logic [BUD_W-1:0]   budget_r;
  logic               out_valid_r;
  out_t               out_r;

  logic [CMD_W-1:0]   raw;
  logic [CMD_W-1:0]   abs_cmd;
  logic [MAG_W-1:0]   mag_in;
  logic [TS_W-1:0]    diff;
  logic [RISE_W-1:0]  rise;
  logic [M9_W-1:0]    m9;
  logic [RCP_W-1:0]   rcp;
  logic [MAG_W-1:0]   mag_scaled;
  logic [RISE_W-1:0]  duty_prod;
  logic [DUTY_W-1:0]  duty;

  always_comb begin
    raw     = in_data.command;
    abs_cmd = raw[CMD_W-1] ? (~raw + 18'd1) : raw;
    mag_in  = (abs_cmd > {1'b0, FULL_SCALE}) ? FULL_SCALE : abs_cmd[MAG_W-1:0];
    diff    = in_data.timestamp_us - last_time_r;

    rise    = {mag_r - last_mag_r, 8'd0};
    sts.scale_req = (mag_r > last_mag_r) && (mag_r > floor_r)
                    && (BUD_W'(rise) > budget_r);
    sts.out_free  = !out_valid_r || out_ready;

    m9         = {mag_r, 3'd0} + M9_W'(mag_r);
    rcp        = RCP_W'(m9) * RCP_W'(DIV10_MUL);
    mag_scaled = MAG_W'(rcp >> DIV10_SH);

    duty_prod  = {mag_r, 8'd0} - RISE_W'(mag_r);
    duty       = duty_prod[23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rise_r  <= MAX_RISE_RST;
      floor_r     <= FLOOR_RST;
      last_mag_r  <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_RISE:    max_rise_r <= cfg_data[MAXR_W-1:0];
          REG_FLOOR_LEVEL: floor_r    <= cfg_data[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        last_mag_r  <= mag_r;
        last_time_r <= ts_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r     <= mag_in;
      neg_r     <= raw[CMD_W-1];
      ts_r      <= in_data.timestamp_us;
      elapsed_r <= diff[EL_W-1:0];
      limited_r <= 1'b0;
    end
    if (cmd.mult) begin
      budget_r <= BUD_W'(max_rise_r) * BUD_W'(elapsed_r);
    end
    if (cmd.scale) begin
      mag_r     <= mag_scaled;
      limited_r <= 1'b1;
    end
    if (cmd.finish) begin
      out_r.duty_a  <= neg_r ? duty : '0;
      out_r.duty_b  <= neg_r ? '0 : duty;
      out_r.limited <= limited_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/motor_slew_limited_pwm.sv @@
// ----------------------------------------------------------------------------
// motor_slew_limited_pwm
// Slew rate limited speed command to H-bridge PWM duty pair.
//
//   channel  signals                              role
//   in       in_valid in_ready in_data            command and timestamp
//   out      out_valid out_ready out_data         duty pair and limited flag
//   cfg      cfg_valid cfg_ready cfg_index/data   max_rise, floor_level
//
// each item runs load, budget multiply, n 0.9 scaling steps (0 to 89), write;
// the scaling loop runs one step a cycle on a single reciprocal multiplier.
// one item is in work at a time; the next is taken while a result waits.
// the result register holds until out_ready; a stalled result blocks only
// the end of the following item.
// reset is synchronous; config, last item and out_valid reset, no clearing pass.
// ----------------------------------------------------------------------------
module motor_slew_limited_pwm #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mslp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mslp_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mslp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mslp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mslp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mslp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mslp_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/mslp_checker.sv @@
// ----------------------------------------------------------------------------
// mslp_checker
// Port level checks for the slew limited bridge PWM block.
// ----------------------------------------------------------------------------
module mslp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input mslp_pkg::out_t out_data
);

  // only one bridge leg driven
  a_one_leg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.duty_a == 8'd0 || out_data.duty_b == 8'd0))
    else $error("both bridge legs driven");

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // reset empties the block
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind motor_slew_limited_pwm mslp_checker u_mslp_checker (.*);

@@ dv/tb_motor_slew_limited_pwm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_slew_limited_pwm
// Self-checking bench for the slew limited bridge PWM block. A queue of
// commands feeds a valid/ready driver; a monitor predicts the duty pair and
// limited flag of every accepted item and compares them, field by field, in
// order with the results. Phases change max_rise and floor_level (and write unused
// indices) while idle and vary the idling of both sides.
// ----------------------------------------------------------------------------
module tb_motor_slew_limited_pwm;
  import mslp_pkg::*;

  localparam int TB_TIME_BITS = 32;
  localparam logic [63:0] ELAPSED_MASK = (TB_TIME_BITS >= 32) ? 64'hFFFF_FFFF :
                                         ((64'd1 << TB_TIME_BITS) - 64'd1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_ONES = 8'hFF;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 135;
  localparam int END_PAUSE    = 150;
  localparam int STALL_LIMIT  = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_t  pending_items[$];
  out_t expected_duties[$];
  logic in_taken = 1'b0;
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;

  // predictor state and registers
  logic [MAXR_W-1:0]  max_rise_q = MAX_RISE_RST;
  logic [FLOOR_W-1:0] floor_q = FLOOR_RST;
  logic [MAG_W-1:0]   last_mag_q = '0;
  logic [TS_W-1:0]    last_stamp_q = '0;

  motor_slew_limited_pwm #(
    .TIME_BITS(TB_TIME_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_t predict_bridge_duty(input in_t item);
    logic [CMD_W-1:0] raw;
    logic             negative;
    logic [31:0]      mag;
    logic [31:0]      delta;
    logic [63:0]      budget;
    logic [63:0]      rise;
    logic [31:0]      duty;
    out_t             res;
    raw = item.command;
    negative = raw[CMD_W-1];
    mag = negative ? (32'h40000 - {14'd0, raw}) : {14'd0, raw};
    if (mag > 32'(FULL_SCALE)) begin
      mag = 32'(FULL_SCALE);
    end
    res = '0;
    if (mag > 32'(last_mag_q)) begin
      delta = item.timestamp_us - last_stamp_q;
      budget = 64'(max_rise_q) * ({32'd0, delta} & ELAPSED_MASK);
      while (mag > 32'(last_mag_q) && mag > 32'(floor_q)) begin
        rise = {32'd0, mag - 32'(last_mag_q)} << 8;
        if (rise <= budget) break;
        mag = (mag * 9) / 10;
        res.limited = 1'b1;
      end
    end
    last_mag_q = mag[MAG_W-1:0];
    last_stamp_q = item.timestamp_us;
    duty = (mag * 255) >> 16;
    if (duty > 255) begin
      duty = 255;
    end
    if (negative) begin
      res.duty_a = duty[DUTY_W-1:0];
    end else begin
      res.duty_b = duty[DUTY_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_item(input int cmd, input logic [TS_W-1:0] stamp);
    in_t item;
    item.command = cmd[CMD_W-1:0];
    item.timestamp_us = stamp;
    pending_items.push_back(item);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_drained();
    while (pending_items.size() != 0 || in_valid || expected_duties.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    out_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_RISE:    max_rise_q = cfg_data[MAXR_W-1:0];
          REG_FLOOR_LEVEL: floor_q = cfg_data[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_duties.push_back(predict_bridge_duty(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          report_mismatch($sformatf("result a=%0d b=%0d lim=%0d with no item pending",
                                    out_data.duty_a, out_data.duty_b, out_data.limited));
        end else begin
          want = expected_duties.pop_front();
          if (out_data.duty_a !== want.duty_a)
            report_mismatch($sformatf("duty_a got %0d want %0d",
                                      out_data.duty_a, want.duty_a));
          if (out_data.duty_b !== want.duty_b)
            report_mismatch($sformatf("duty_b got %0d want %0d",
                                      out_data.duty_b, want.duty_b));
          if (out_data.limited !== want.limited)
            report_mismatch($sformatf("limited got %0d want %0d",
                                      out_data.limited, want.limited));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int               phase;
    int               n;
    int               pick;
    int               cmd;
    logic [TS_W-1:0]  clock_us;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    clock_us = '0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 32;
        recv_stall_pct = 56;
      end else if (phase < 4) begin
        send_idle_pct = 56;
        recv_stall_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (phase)
        1: begin
          write_register(REG_MAX_RISE, 32'd0);
          write_register(REG_FLOOR_LEVEL, 32'd0);
        end
        2: begin
          write_register(REG_MAX_RISE, 32'h000F_FFFF);
          write_register(REG_FLOOR_LEVEL, 32'(FULL_SCALE));
        end
        3: begin
          write_register(REG_MAX_RISE, $urandom_range(0, 40000));
          write_register(REG_FLOOR_LEVEL, $urandom_range(0, 3000));
          write_register(REG_SPARE, $urandom);
          write_register(REG_ALL_ONES, $urandom);
        end
        4: begin
          write_register(REG_MAX_RISE, ($urandom & 32'hFFF0_0000) | 32'd16777);
          write_register(REG_FLOOR_LEVEL, ($urandom & 32'hFFFE_0000) | 32'd300);
        end
        5: begin
          write_register(REG_MAX_RISE, $urandom_range(1, 2000));
          write_register(REG_FLOOR_LEVEL, 32'd1);
        end
        default: ;
      endcase
      if (phase == 0) begin
        push_item(0, 32'd0);
        push_item(65536, 32'd1);                 // big rise in one microsecond
        push_item(65536, 32'd5001);
        push_item(-65536, 32'd5001);             // same magnitude, other channel
        push_item(0, 32'd6000);
        push_item(-131072, 32'd7000);            // most negative field, rate just short
        push_item(131071, 32'd20000);            // most positive field
        push_item(65537, 32'd20000);
        push_item(1, 32'd20001);
        push_item(-1, 32'd20002);
        push_item(300, 32'd20002);               // rise at zero elapsed, under floor
        push_item(40000, 32'd20002);             // rise at zero elapsed, above floor
        push_item(100, 32'hFFFF_FF00);
        push_item(65536, 32'h0000_0400);         // timestamp wraps
        push_item(-65536, 32'hFFFF_FFFF);
        push_item(0, 32'hFFFF_FFFF);
        push_item(32768, 32'd0);
        clock_us = 32'd0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10)
          clock_us = clock_us;
        else if (pick < 60)
          clock_us = clock_us + $urandom_range(1, 2000);
        else if (pick < 85)
          clock_us = clock_us + $urandom_range(1, 100000);
        else
          clock_us = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          cmd = int'($urandom_range(0, 131072)) - 65536;
        end else if (pick < 75) begin
          cmd = int'($urandom_range(0, 2000)) - 1000;
        end else if (pick < 88) begin
          case ($urandom_range(0, 2))
            0: cmd = int'(FULL_SCALE);
            1: cmd = -int'(FULL_SCALE);
            default: cmd = 0;
          endcase
        end else begin
          cmd = int'($urandom);
        end
        push_item(cmd, clock_us);
      end
      wait_until_drained();
    end
    repeat (END_PAUSE) @(posedge clk);
    if (expected_duties.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_duties.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
